// ===== rtl/scrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrp_pkg
// types and constants shared by the submission / completion ring pair
// ----------------------------------------------------------------------------
package scrp_pkg;

    // field widths
    localparam int OP_W     = 2;
    localparam int CODE_W   = 8;
    localparam int OFFSET_W = 48;
    localparam int TAG_W    = 64;
    localparam int BYTES_W  = 13;
    localparam int COUNT_W  = 4;
    localparam int SIZE_W   = 49;

    // request entry as stored in the submission ring, code in the low bits
    localparam int SUB_ENTRY_W  = CODE_W + OFFSET_W + TAG_W;
    // completion entry: error flag above the tag
    localparam int COMP_ENTRY_W = TAG_W + 1;

    // item kinds
    localparam logic [OP_W-1:0] OP_SUBMIT   = 2'd0;
    localparam logic [OP_W-1:0] OP_DOORBELL = 2'd1;
    localparam logic [OP_W-1:0] OP_REAP     = 2'd2;

    localparam logic [CODE_W-1:0]  READ_CODE   = 8'd22;
    localparam logic [BYTES_W-1:0] BLOCK_BYTES = 13'd4096;

    // register index decoded from paddr[3]
    localparam logic CFG_IDX_STORAGE_SIZE = 1'b0;
    localparam logic [SIZE_W-1:0] STORAGE_SIZE_RESET = 49'd65536;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_CHECK,
        ST_REAP,
        ST_RESULT
    } state_t;

    // declared msb first so that accepted lands in bit 0
    typedef struct packed {
        logic [COUNT_W-1:0] dropped_count;
        logic [COUNT_W-1:0] drained_count;
        logic               completion_error;
        logic [BYTES_W-1:0] completion_bytes;
        logic [TAG_W-1:0]   completion_tag;
        logic               accepted;
    } result_t;

endpackage

// ===== rtl/scrp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrp_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module scrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/submission_completion_ring_pair_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// submission_completion_ring_pair_top
// submission ring and completion ring under one small sequencer
// ----------------------------------------------------------------------------
// usage
//   s_* carries items: s_tuser is the kind (submit, doorbell, reap), s_tdata
//   the request. m_* returns exactly one result per item. the apb port
//   writes and reads storage_size at byte address 0.
// timing
//   submit, unknown kinds and empty-ring reaps: result registered from the
//   transfer. reap on a non-empty ring: registered read of the completion
//   ram, then the result. doorbell: per queued request a registered read of
//   the submission ram, then the range check and completion write; the
//   result once the submission ring is empty.
//   s_tready is high only while the sequencer is idle, so one item is at
//   work at a time; a new item is taken while a result still waits in the
//   output register.
// reset
//   rst_n clears ring pointers, the sequencer and the output valid, and
//   sets storage_size to 65536. ring contents are not cleared.
// stall
//   if m_tready is low, the result stays in the output register; a second
//   finished result parks in a holding register and the sequencer waits.
// ----------------------------------------------------------------------------
module submission_completion_ring_pair_top #(
    parameter int SUB_DEPTH  = 8,
    parameter int COMP_DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,   // request_code[7:0], byte_offset[55:8], user_tag[119:56]
    input  logic [1:0]   s_tuser,   // op[1:0]
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,   // accepted[0], completion_tag[64:1],
                                    // completion_bytes[77:65], completion_error[78],
                                    // drained_count[82:79], dropped_count[86:83], zero[87]
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    localparam int SUB_AW  = $clog2(SUB_DEPTH);
    localparam int COMP_AW = $clog2(COMP_DEPTH);
    localparam logic [SUB_AW-1:0]  SUB_LAST  = SUB_AW'(SUB_DEPTH - 1);
    localparam logic [COMP_AW-1:0] COMP_LAST = COMP_AW'(COMP_DEPTH - 1);

    // sequencer
    scrp_pkg::state_t state_reg, state_next;

    // ring pointers: slot plus wrap bit, same as a counter modulo twice the depth
    logic [SUB_AW-1:0]  sub_head_reg, sub_head_next;
    logic               sub_head_wrap_reg, sub_head_wrap_next;
    logic [SUB_AW-1:0]  sub_tail_reg, sub_tail_next;
    logic               sub_tail_wrap_reg, sub_tail_wrap_next;
    logic [COMP_AW-1:0] comp_head_reg, comp_head_next;
    logic               comp_head_wrap_reg, comp_head_wrap_next;
    logic [COMP_AW-1:0] comp_tail_reg, comp_tail_next;
    logic               comp_tail_wrap_reg, comp_tail_wrap_next;

    // doorbell counters, 4 bits wrap like the masked field
    logic [scrp_pkg::COUNT_W-1:0] drained_reg, drained_next;
    logic [scrp_pkg::COUNT_W-1:0] dropped_reg, dropped_next;

    logic [scrp_pkg::SIZE_W-1:0] storage_size_reg;

    // output register and holding register
    logic              m_valid_reg, m_valid_next;
    scrp_pkg::result_t out_reg, out_next;
    scrp_pkg::result_t hold_reg, hold_next;

    scrp_pkg::result_t res_value;
    logic              res_load;

    // ram ports
    logic                                sub_wr_en;
    logic                                sub_rd_en;
    logic [scrp_pkg::SUB_ENTRY_W-1:0]    sub_rd_data;
    logic                                comp_wr_en;
    logic                                comp_rd_en;
    logic [scrp_pkg::COMP_ENTRY_W-1:0]   comp_wr_data;
    logic [scrp_pkg::COMP_ENTRY_W-1:0]   comp_rd_data;

    // fields of the entry being drained
    logic [scrp_pkg::CODE_W-1:0]   ent_code;
    logic [scrp_pkg::OFFSET_W-1:0] ent_offset;
    logic [scrp_pkg::TAG_W-1:0]    ent_tag;
    logic [scrp_pkg::SIZE_W-1:0]   ent_end;
    logic                          ent_good;

    logic s_fire;
    logic out_free;
    logic sub_empty, sub_full, comp_empty, comp_full;
    logic cfg_wr;

    assign s_tready = (state_reg == scrp_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign sub_empty  = (sub_head_reg == sub_tail_reg) && (sub_head_wrap_reg == sub_tail_wrap_reg);
    assign sub_full   = (sub_head_reg == sub_tail_reg) && (sub_head_wrap_reg != sub_tail_wrap_reg);
    assign comp_empty = (comp_head_reg == comp_tail_reg)
                        && (comp_head_wrap_reg == comp_tail_wrap_reg);
    assign comp_full  = (comp_head_reg == comp_tail_reg)
                        && (comp_head_wrap_reg != comp_tail_wrap_reg);

    // read check: end of block formed at 49 bits so it cannot wrap
    assign ent_code   = sub_rd_data[scrp_pkg::CODE_W-1:0];
    assign ent_offset = sub_rd_data[scrp_pkg::CODE_W +: scrp_pkg::OFFSET_W];
    assign ent_tag    = sub_rd_data[scrp_pkg::CODE_W + scrp_pkg::OFFSET_W +: scrp_pkg::TAG_W];
    assign ent_end    = {1'b0, ent_offset} + {36'd0, scrp_pkg::BLOCK_BYTES};
    assign ent_good   = (ent_code == scrp_pkg::READ_CODE) && (ent_end <= storage_size_reg);

    assign comp_wr_data = {!ent_good, ent_tag};

    scrp_ram #(
        .WIDTH (scrp_pkg::SUB_ENTRY_W),
        .DEPTH (SUB_DEPTH)
    ) u_sub_ram (
        .clk     (clk),
        .wr_en   (sub_wr_en),
        .wr_addr (sub_tail_reg),
        .wr_data (s_tdata),
        .rd_en   (sub_rd_en),
        .rd_addr (sub_head_reg),
        .rd_data (sub_rd_data)
    );

    scrp_ram #(
        .WIDTH (scrp_pkg::COMP_ENTRY_W),
        .DEPTH (COMP_DEPTH)
    ) u_comp_ram (
        .clk     (clk),
        .wr_en   (comp_wr_en),
        .wr_addr (comp_tail_reg),
        .wr_data (comp_wr_data),
        .rd_en   (comp_rd_en),
        .rd_addr (comp_head_reg),
        .rd_data (comp_rd_data)
    );

    // sequencer: next state, pointer updates and result formation
    always_comb
    begin
        state_next          = state_reg;
        sub_head_next       = sub_head_reg;
        sub_head_wrap_next  = sub_head_wrap_reg;
        sub_tail_next       = sub_tail_reg;
        sub_tail_wrap_next  = sub_tail_wrap_reg;
        comp_head_next      = comp_head_reg;
        comp_head_wrap_next = comp_head_wrap_reg;
        comp_tail_next      = comp_tail_reg;
        comp_tail_wrap_next = comp_tail_wrap_reg;
        drained_next        = drained_reg;
        dropped_next        = dropped_reg;
        out_next            = out_reg;
        hold_next           = hold_reg;
        m_valid_next        = m_valid_reg && !m_tready;
        sub_wr_en           = 1'b0;
        sub_rd_en           = 1'b0;
        comp_wr_en          = 1'b0;
        comp_rd_en          = 1'b0;
        res_load            = 1'b0;
        res_value           = '0;

        case (state_reg)
            scrp_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    case (s_tuser)
                        scrp_pkg::OP_SUBMIT:
                        begin
                            res_load = 1'b1;
                            if (!sub_full)
                            begin
                                sub_wr_en          = 1'b1;
                                res_value.accepted = 1'b1;
                                if (sub_tail_reg == SUB_LAST)
                                begin
                                    sub_tail_next      = '0;
                                    sub_tail_wrap_next = !sub_tail_wrap_reg;
                                end
                                else
                                begin
                                    sub_tail_next = sub_tail_reg + 1'b1;
                                end
                            end
                        end
                        scrp_pkg::OP_DOORBELL:
                        begin
                            drained_next = '0;
                            dropped_next = '0;
                            state_next   = scrp_pkg::ST_DRAIN;
                        end
                        scrp_pkg::OP_REAP:
                        begin
                            if (comp_empty)
                            begin
                                res_load = 1'b1;
                            end
                            else
                            begin
                                comp_rd_en = 1'b1;
                                state_next = scrp_pkg::ST_REAP;
                                if (comp_head_reg == COMP_LAST)
                                begin
                                    comp_head_next      = '0;
                                    comp_head_wrap_next = !comp_head_wrap_reg;
                                end
                                else
                                begin
                                    comp_head_next = comp_head_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            // unknown kind: all-zero result, no ring or counter change
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            scrp_pkg::ST_DRAIN:
            begin
                if (sub_empty)
                begin
                    res_value.drained_count = drained_reg;
                    res_value.dropped_count = dropped_reg;
                    res_load                = 1'b1;
                end
                else
                begin
                    sub_rd_en  = 1'b1;
                    state_next = scrp_pkg::ST_CHECK;
                end
            end
            scrp_pkg::ST_CHECK:
            begin
                if (comp_full)
                begin
                    dropped_next = dropped_reg + 1'b1;
                end
                else
                begin
                    comp_wr_en = 1'b1;
                    if (comp_tail_reg == COMP_LAST)
                    begin
                        comp_tail_next      = '0;
                        comp_tail_wrap_next = !comp_tail_wrap_reg;
                    end
                    else
                    begin
                        comp_tail_next = comp_tail_reg + 1'b1;
                    end
                end
                if (sub_head_reg == SUB_LAST)
                begin
                    sub_head_next      = '0;
                    sub_head_wrap_next = !sub_head_wrap_reg;
                end
                else
                begin
                    sub_head_next = sub_head_reg + 1'b1;
                end
                drained_next = drained_reg + 1'b1;
                state_next   = scrp_pkg::ST_DRAIN;
            end
            scrp_pkg::ST_REAP:
            begin
                res_value.accepted         = 1'b1;
                res_value.completion_tag   = comp_rd_data[scrp_pkg::TAG_W-1:0];
                res_value.completion_error = comp_rd_data[scrp_pkg::TAG_W];
                res_value.completion_bytes = comp_rd_data[scrp_pkg::TAG_W]
                                             ? '0 : scrp_pkg::BLOCK_BYTES;
                res_load                   = 1'b1;
            end
            scrp_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    out_next     = hold_reg;
                    m_valid_next = 1'b1;
                    state_next   = scrp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scrp_pkg::ST_IDLE;
            end
        endcase

        // a finished result goes straight out, or waits in the holding register
        if (res_load)
        begin
            if (out_free)
            begin
                out_next     = res_value;
                m_valid_next = 1'b1;
                state_next   = scrp_pkg::ST_IDLE;
            end
            else
            begin
                hold_next  = res_value;
                state_next = scrp_pkg::ST_RESULT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= scrp_pkg::ST_IDLE;
            sub_head_reg       <= '0;
            sub_head_wrap_reg  <= 1'b0;
            sub_tail_reg       <= '0;
            sub_tail_wrap_reg  <= 1'b0;
            comp_head_reg      <= '0;
            comp_head_wrap_reg <= 1'b0;
            comp_tail_reg      <= '0;
            comp_tail_wrap_reg <= 1'b0;
            drained_reg        <= '0;
            dropped_reg        <= '0;
            m_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            sub_head_reg       <= sub_head_next;
            sub_head_wrap_reg  <= sub_head_wrap_next;
            sub_tail_reg       <= sub_tail_next;
            sub_tail_wrap_reg  <= sub_tail_wrap_next;
            comp_head_reg      <= comp_head_next;
            comp_head_wrap_reg <= comp_head_wrap_next;
            comp_tail_reg      <= comp_tail_next;
            comp_tail_wrap_reg <= comp_tail_wrap_next;
            drained_reg        <= drained_next;
            dropped_reg        <= dropped_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            storage_size_reg <= scrp_pkg::STORAGE_SIZE_RESET;
        end
        else if (cfg_wr && (paddr[3] == scrp_pkg::CFG_IDX_STORAGE_SIZE))
        begin
            storage_size_reg <= pwdata[scrp_pkg::SIZE_W-1:0];
        end
    end

    assign prdata = (paddr[3] == scrp_pkg::CFG_IDX_STORAGE_SIZE)
                    ? {15'd0, storage_size_reg} : 64'd0;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    // a submit refused by a full ring leaves the tail alone
    a_full_submit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (s_tuser == scrp_pkg::OP_SUBMIT) && sub_full)
        |=> ($stable(sub_tail_reg) && $stable(sub_tail_wrap_reg)))
        else $error("submit into full submission ring moved the tail");

    // no completion written over an unreaped one
    a_comp_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        comp_wr_en |-> !comp_full)
        else $error("completion written into full ring");

    // the holding register is used only while the output register is occupied
    a_hold_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == scrp_pkg::ST_RESULT) |-> m_valid_reg)
        else $error("result held while output register empty");

    // reap of a non-empty ring moves to the reap state to wait for the ram read
    a_reap_reads_ram: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (s_tuser == scrp_pkg::OP_REAP) && !comp_empty)
        |=> (state_reg == scrp_pkg::ST_REAP))
        else $error("reap did not wait for completion ram read");

    // drain stops only on an empty submission ring
    a_drain_ends_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == scrp_pkg::ST_DRAIN) && res_load) |-> sub_empty)
        else $error("doorbell finished with requests still queued");

endmodule
